@@ hw/rtl/nshp_pkg.sv @@
// Shared constants, command codes and controller/datapath interface types.
package nshp_pkg;

    localparam int MAX_SITES  = 64;
    localparam int SITE_AW    = 6;
    localparam int COORD_W    = 24;
    localparam int BOX_W      = 23;
    localparam int ACT_W      = 7;
    localparam int PERIOD_W   = 16;
    localparam int COUNT_W    = 32;
    localparam int CMD_W      = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 23;
    localparam int IN_DATA_W  = 224;
    localparam int OUT_DATA_W = 112;
    localparam int NUM_LANES  = 6;
    localparam int MAG_W      = 25;
    localparam int SQ_W       = 2 * MAG_W;
    localparam int DIST_W     = SQ_W + 2;
    localparam int BSQ_W      = 2 * BOX_W;

    localparam logic [2:0] BOUND_FACTOR = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_BOX_X        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_Y        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_Z        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_SITES = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_EVERY = 3'd4;

    typedef enum logic [CMD_W-1:0]
    {
        CMD_LOAD   = 2'd0,
        CMD_SAMPLE = 2'd1,
        CMD_READ   = 2'd2
    } cmd_t;

    typedef struct packed
    {
        logic               accept;
        logic               scan_issue;
        logic [SITE_AW-1:0] scan_index;
        logic               hist_rd_bin;
        logic               hist_rd_win;
        logic               hist_wr;
        logic               emit;
    } dp_cmd_t;

    typedef struct packed
    {
        logic             sample_due;
        logic             pipe_busy;
        logic [ACT_W-1:0] scan_count;
    } dp_stat_t;

endpackage

@@ hw/rtl/nearest_site_histogram_periodic_core.sv @@
// Top level of the nearest-site periodic histogram block.
//
// Input stream (s_*): one command per transfer. s_tuser carries cmd (load site,
// sample call, read histogram bin); s_tdata carries site_index and the site,
// head and tail coordinates. Output stream (m_*): exactly one result transfer
// per command, in order. m_tuser is the sampled flag, m_tdata holds the nearest
// indices, the two histogram counts and the running sample total.
// Commands are processed one at a time. A load, an unused command or a sample
// call that is not taken goes straight to the result; a read first does one
// histogram memory read. A taken sample scans the first N site table entries,
// N being active_sites held to 1..64, one entry per cycle through a
// five-stage distance pipeline that serves head and tail together, then the
// winning bins get a read-modify-write.
// The result sits in an output register; the next command is accepted while
// it waits, but its own result is held until m_tready takes the previous one.
// Reset restores the configuration defaults, clears the call phase, sample
// total and the histogram valid bits (every bin reads zero); the site table
// is not cleared and must be loaded before it is searched.
module nearest_site_histogram_periodic_core
(
    input  logic                            clk,
    input  logic                            rst_n,
    // slave stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [5:0] site_index, [29:6] site_x, [53:30] site_y, [77:54] site_z,
    // [101:78] head_x, [125:102] head_y, [149:126] head_z,
    // [173:150] tail_x, [197:174] tail_y, [221:198] tail_z, [223:222] zero
    input  logic [nshp_pkg::IN_DATA_W-1:0]  s_tdata,
    // [1:0] cmd
    input  logic [nshp_pkg::CMD_W-1:0]      s_tuser,
    // master stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [5:0] head_nearest, [11:6] tail_nearest, [43:12] head_hits,
    // [75:44] tail_hits, [107:76] samples_taken, [111:108] zero
    output logic [nshp_pkg::OUT_DATA_W-1:0] m_tdata,
    // [0] sampled
    output logic                            m_tuser,
    // configuration write port
    input  logic                            cfg_we,
    input  logic [nshp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [nshp_pkg::CFG_DATA_W-1:0] cfg_data
);
    import nshp_pkg::*;

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    // Sequence each command; hold s_tready low until its result is registered.
    nshp_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_cmd    (s_tuser),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .stat      (dp_stat),
        .cmd       (dp_cmd)
    );

    // Storage, distance pipeline and result register.
    nshp_dp u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_cmd      (s_tuser),
        .in_data     (s_tdata),
        .cmd         (dp_cmd),
        .stat        (dp_stat),
        .out_sampled (m_tuser),
        .out_data    (m_tdata)
    );

endmodule

@@ hw/rtl/nshp_ctrl.sv @@
// Controller state machine: sequences load, read and sample-scan commands.
module nshp_ctrl
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic [nshp_pkg::CMD_W-1:0] in_cmd,
    output logic                      in_ready,
    output logic                      out_valid,
    input  logic                      out_ready,
    input  nshp_pkg::dp_stat_t        stat,
    output nshp_pkg::dp_cmd_t         cmd
);
    import nshp_pkg::*;

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_DRAIN,
        S_WIN_RD,
        S_WIN_WR,
        S_EMIT
    } state_t;

    state_t           state_reg;
    logic [ACT_W-1:0] scan_cnt_reg;
    logic             out_valid_reg;
    logic             accept;
    logic             out_free;
    logic             scan_last;

    assign accept    = in_valid && (state_reg == S_IDLE);
    assign out_free  = !out_valid_reg || out_ready;
    assign scan_last = (scan_cnt_reg == (stat.scan_count - ACT_W'(1)));
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd             = '0;
        cmd.accept      = accept;
        cmd.scan_issue  = (state_reg == S_SCAN);
        cmd.scan_index  = scan_cnt_reg[SITE_AW-1:0];
        cmd.hist_rd_bin = (state_reg == S_READ);
        cmd.hist_rd_win = (state_reg == S_WIN_RD);
        cmd.hist_wr     = (state_reg == S_WIN_WR);
        cmd.emit        = (state_reg == S_EMIT) && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            scan_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        scan_cnt_reg <= '0;
                        unique case (in_cmd)
                            CMD_SAMPLE: state_reg <= stat.sample_due ? S_SCAN : S_EMIT;
                            CMD_READ:   state_reg <= S_READ;
                            default:    state_reg <= S_EMIT;
                        endcase
                    end
                end
                S_READ:
                begin
                    state_reg <= S_EMIT;
                end
                S_SCAN:
                begin
                    scan_cnt_reg <= scan_cnt_reg + ACT_W'(1);
                    if (scan_last)
                    begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    if (!stat.pipe_busy)
                    begin
                        state_reg <= S_WIN_RD;
                    end
                end
                S_WIN_RD:
                begin
                    state_reg <= S_WIN_WR;
                end
                S_WIN_WR:
                begin
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ hw/rtl/nshp_dp.sv @@
// Datapath: config, site table, distance pipeline, histograms and result register.
module nshp_dp
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [nshp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [nshp_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic [nshp_pkg::CMD_W-1:0]      in_cmd,
    input  logic [nshp_pkg::IN_DATA_W-1:0]  in_data,
    input  nshp_pkg::dp_cmd_t               cmd,
    output nshp_pkg::dp_stat_t              stat,
    output logic                            out_sampled,
    output logic [nshp_pkg::OUT_DATA_W-1:0] out_data
);
    import nshp_pkg::*;

    // Minimum-image magnitude along one axis, one wrap correction.
    function automatic logic [MAG_W-1:0] axis_mag
    (
        input logic [COORD_W-1:0] s,
        input logic [COORD_W-1:0] p,
        input logic [BOX_W-1:0]   b
    );
        logic signed [COORD_W+1:0] d;
        logic signed [COORD_W+1:0] bn;
        logic signed [COORD_W+1:0] dc;
        logic signed [COORD_W+2:0] d2;
        logic signed [COORD_W+2:0] bw;
        logic        [COORD_W+1:0] mag;
        d  = $signed({{2{s[COORD_W-1]}}, s}) - $signed({{2{p[COORD_W-1]}}, p});
        bn = $signed({3'b000, b});
        d2 = $signed({d, 1'b0});
        bw = $signed({4'b0000, b});
        if (d2 > bw)
        begin
            dc = d - bn;
        end
        else if (d2 < -bw)
        begin
            dc = d + bn;
        end
        else
        begin
            dc = d;
        end
        mag = dc[COORD_W+1] ? $unsigned(-dc) : $unsigned(dc);
        return mag[MAG_W-1:0];
    endfunction

    // configuration
    logic [BOX_W-1:0]    box_reg [3];
    logic [ACT_W-1:0]    active_sites_reg;
    logic [PERIOD_W-1:0] sample_every_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_reg[0]       <= BOX_W'(65536);
            box_reg[1]       <= BOX_W'(65536);
            box_reg[2]       <= BOX_W'(65536);
            active_sites_reg <= ACT_W'(1);
            sample_every_reg <= PERIOD_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BOX_X:        box_reg[0]       <= cfg_data[BOX_W-1:0];
                REG_BOX_Y:        box_reg[1]       <= cfg_data[BOX_W-1:0];
                REG_BOX_Z:        box_reg[2]       <= cfg_data[BOX_W-1:0];
                REG_ACTIVE_SITES: active_sites_reg <= cfg_data[ACT_W-1:0];
                REG_SAMPLE_EVERY: sample_every_reg <= cfg_data[PERIOD_W-1:0];
                default:          ;
            endcase
        end
    end

    assign stat.scan_count = (active_sites_reg == '0) ? ACT_W'(1)
                           : (active_sites_reg > ACT_W'(MAX_SITES)) ? ACT_W'(MAX_SITES)
                           : active_sites_reg;

    // search bound 5 * (bx^2 + by^2 + bz^2), two register stages
    logic [BSQ_W-1:0]  bsq_reg [3];
    logic [DIST_W-1:0] bound_reg;
    logic [DIST_W-1:0] bsq_sum;

    assign bsq_sum = DIST_W'(bsq_reg[0]) + DIST_W'(bsq_reg[1]) + DIST_W'(bsq_reg[2]);

    always_ff @(posedge clk)
    begin
        for (int a = 0; a < 3; a++)
        begin
            bsq_reg[a] <= BSQ_W'(box_reg[a]) * BSQ_W'(box_reg[a]);
        end
        bound_reg <= bsq_sum * DIST_W'(BOUND_FACTOR);
    end

    // input field unpack: site_index, then nine coordinates
    logic [SITE_AW-1:0] in_idx;
    logic [COORD_W-1:0] in_coord [9];

    assign in_idx = in_data[SITE_AW-1:0];

    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            in_coord[k] = in_data[SITE_AW + k*COORD_W +: COORD_W];
        end
    end

    // call phase
    logic [PERIOD_W-1:0] phase_reg;
    logic [PERIOD_W:0]   period;
    logic [PERIOD_W:0]   phase_inc;

    assign period          = (sample_every_reg == '0) ? (PERIOD_W+1)'(1)
                                                      : {1'b0, sample_every_reg};
    assign phase_inc       = {1'b0, phase_reg} + (PERIOD_W+1)'(1);
    assign stat.sample_due = (phase_inc >= period);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
        end
        else if (cmd.accept && (in_cmd == CMD_SAMPLE))
        begin
            phase_reg <= stat.sample_due ? '0 : phase_inc[PERIOD_W-1:0];
        end
    end

    // item fields held for the duration of the command
    logic [CMD_W-1:0]   cmd_reg;
    logic [SITE_AW-1:0] idx_reg;
    logic [COORD_W-1:0] pt_reg [NUM_LANES];
    logic               sampled_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            cmd_reg     <= in_cmd;
            idx_reg     <= in_idx;
            sampled_reg <= (in_cmd == CMD_SAMPLE) && stat.sample_due;
            for (int l = 0; l < NUM_LANES; l++)
            begin
                pt_reg[l] <= in_coord[3 + l];
            end
        end
    end

    // site table
    logic [3*COORD_W-1:0] site_mem [MAX_SITES];
    logic [3*COORD_W-1:0] site_rd_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.accept && (in_cmd == CMD_LOAD))
        begin
            site_mem[in_idx] <= {in_coord[2], in_coord[1], in_coord[0]};
        end
        if (cmd.scan_issue)
        begin
            site_rd_reg <= site_mem[cmd.scan_index];
        end
    end

    // distance pipeline: read, wrap, square, sum, compare
    logic               s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic [SITE_AW-1:0] s1_idx_reg, s2_idx_reg, s3_idx_reg, s4_idx_reg;
    logic [MAG_W-1:0]   mag_reg [NUM_LANES];
    logic [SQ_W-1:0]    sq_reg  [NUM_LANES];
    logic [DIST_W-1:0]  sum_reg [2];
    logic [DIST_W-1:0]  best_reg [2];
    logic [SITE_AW-1:0] win_reg  [2];
    logic               scan_first;

    assign stat.pipe_busy = s1_valid_reg || s2_valid_reg || s3_valid_reg || s4_valid_reg;
    // first entry of a scan reaches the square stage; the bound has settled by now
    assign scan_first     = s2_valid_reg && !s3_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= cmd.scan_issue;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_idx_reg <= cmd.scan_index;
        s2_idx_reg <= s1_idx_reg;
        s3_idx_reg <= s2_idx_reg;
        s4_idx_reg <= s3_idx_reg;
        for (int l = 0; l < NUM_LANES; l++)
        begin
            mag_reg[l] <= axis_mag(site_rd_reg[(l % 3)*COORD_W +: COORD_W], pt_reg[l],
                                   box_reg[l % 3]);
            sq_reg[l]  <= SQ_W'(mag_reg[l]) * SQ_W'(mag_reg[l]);
        end
        for (int q = 0; q < 2; q++)
        begin
            sum_reg[q] <= DIST_W'(sq_reg[3*q]) + DIST_W'(sq_reg[3*q + 1])
                        + DIST_W'(sq_reg[3*q + 2]);
        end
        // strict compare keeps the lower index on ties
        for (int q = 0; q < 2; q++)
        begin
            if (scan_first)
            begin
                best_reg[q] <= bound_reg;
                win_reg[q]  <= '0;
            end
            else if (s4_valid_reg && (sum_reg[q] < best_reg[q]))
            begin
                best_reg[q] <= sum_reg[q];
                win_reg[q]  <= s4_idx_reg;
            end
        end
    end

    // histograms: entry reads zero until first written
    logic [COUNT_W-1:0]   hh_mem [MAX_SITES];
    logic [COUNT_W-1:0]   th_mem [MAX_SITES];
    logic [MAX_SITES-1:0] hh_vld_reg;
    logic [MAX_SITES-1:0] th_vld_reg;
    logic [COUNT_W-1:0]   hh_rd_reg, th_rd_reg;
    logic                 hh_rdv_reg, th_rdv_reg;
    logic [SITE_AW-1:0]   hh_addr, th_addr;
    logic [COUNT_W-1:0]   hh_val, th_val;
    logic [COUNT_W-1:0]   hh_inc, th_inc;
    logic [COUNT_W-1:0]   total_reg;

    assign hh_addr = cmd.hist_rd_bin ? idx_reg : win_reg[0];
    assign th_addr = cmd.hist_rd_bin ? idx_reg : win_reg[1];
    assign hh_val  = hh_rdv_reg ? hh_rd_reg : '0;
    assign th_val  = th_rdv_reg ? th_rd_reg : '0;
    assign hh_inc  = (hh_val == '1) ? hh_val : hh_val + COUNT_W'(1);
    assign th_inc  = (th_val == '1) ? th_val : th_val + COUNT_W'(1);

    always_ff @(posedge clk)
    begin
        if (cmd.hist_rd_bin || cmd.hist_rd_win)
        begin
            hh_rd_reg  <= hh_mem[hh_addr];
            th_rd_reg  <= th_mem[th_addr];
            hh_rdv_reg <= hh_vld_reg[hh_addr];
            th_rdv_reg <= th_vld_reg[th_addr];
        end
        if (cmd.hist_wr)
        begin
            hh_mem[win_reg[0]] <= hh_inc;
            th_mem[win_reg[1]] <= th_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hh_vld_reg <= '0;
            th_vld_reg <= '0;
            total_reg  <= '0;
        end
        else if (cmd.hist_wr)
        begin
            hh_vld_reg[win_reg[0]] <= 1'b1;
            th_vld_reg[win_reg[1]] <= 1'b1;
            if (total_reg != '1)
            begin
                total_reg <= total_reg + COUNT_W'(1);
            end
        end
    end

    // result register
    logic                  out_sampled_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic                  is_read;

    assign is_read = (cmd_reg == CMD_READ);

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_sampled_reg <= sampled_reg;
            out_data_reg    <= OUT_DATA_W'({total_reg,
                                            is_read ? th_val : COUNT_W'(0),
                                            is_read ? hh_val : COUNT_W'(0),
                                            sampled_reg ? win_reg[1] : SITE_AW'(0),
                                            sampled_reg ? win_reg[0] : SITE_AW'(0)});
        end
    end

    assign out_sampled = out_sampled_reg;
    assign out_data    = out_data_reg;

endmodule
